### src/fco_pkg.sv
// ----------------------------------------------------------------------------
// fco_pkg: shared types, constants and helpers for the fly camera block
// Fixed-point widths, CORDIC arctangent table, sequencer states, register map.
// ----------------------------------------------------------------------------
package fco_pkg;

  // CORDIC step count, capped by the table length
  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                   TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int STEP_W          = $clog2(ATAN_ENTRIES);

  // datapath widths
  localparam int ANG_W   = 26;   // Q9.16 degrees
  localparam int Z_W     = 27;   // CORDIC residual angle
  localparam int XY_W    = 34;   // CORDIC Q2.30 with headroom
  localparam int VEC_W   = 16;   // Q1.14
  localparam int POS_W   = 32;   // Q16.16
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 30;   // yaw/pitch accumulation
  localparam int ATAN_W  = 22;

  // angle constants in Q.16 degrees
  localparam logic signed [Z_W-1:0]   QUARTER_TURN = 27'sd5898240;
  localparam logic signed [Z_W-1:0]   HALF_TURN_Z  = 27'sd11796480;
  localparam logic signed [ACC_W-1:0] HALF_TURN    = 30'sd11796480;
  localparam logic signed [ACC_W-1:0] FULL_TURN    = 30'sd23592960;
  localparam logic signed [ACC_W-1:0] PITCH_LIMIT  = 30'sd5832704;
  localparam logic signed [XY_W-1:0]  CORDIC_START = 34'sd652032875;
  localparam logic signed [PROD_W-1:0] UNIT14      = 50'sd16384;
  localparam logic signed [PROD_W-1:0] MUL14_RND   = 50'sd8192;

  // reset state
  localparam logic signed [ANG_W-1:0] YAW_RESET   = -26'sd5898240;
  localparam logic signed [ANG_W-1:0] PITCH_RESET = -26'sd655360;
  localparam logic signed [POS_W-1:0] POS_Z_RESET = 32'sd1179648;

  // register map
  typedef enum logic {
    REG_MOVE_SPEED = 1'b0,
    REG_LOOK_GAIN  = 1'b1
  } reg_idx_t;

  // move directions
  typedef enum logic [2:0] {
    DIR_FWD   = 3'd0,
    DIR_BACK  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_UP    = 3'd4,
    DIR_DOWN  = 3'd5
  } dir_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MV_SPD, S_MV_LAT, S_MV_VEC, S_MV_ADD,
    S_LK_DX, S_LK_DY, S_LK_PIT, S_LK_WRAP, S_CY, S_CP,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_DONE
  } state_t;

  // CORDIC handshake toward the sequencer
  typedef struct packed {
    logic                    done;
    logic signed [VEC_W-1:0] sin_v;
    logic signed [VEC_W-1:0] cos_v;
  } trig_res_t;

  // arctangent of 2^-i in Q.16 degrees
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] r;
    unique case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // clamp to +-1.0 in Q1.14
  function automatic logic signed [VEC_W-1:0] clamp_unit(
      input logic signed [PROD_W-1:0] v);
    logic signed [VEC_W-1:0] r;
    if (v > UNIT14) r = UNIT14[VEC_W-1:0];
    else if (v < -UNIT14) r = -UNIT14[VEC_W-1:0];
    else r = v[VEC_W-1:0];
    return r;
  endfunction

  // Q1.14 x Q1.14 product, rounded back to Q1.14
  function automatic logic signed [VEC_W-1:0] mul14(
      input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = (p + MUL14_RND) >>> 14;
    return clamp_unit(s);
  endfunction

endpackage

### src/fco_cordic.sv
// ----------------------------------------------------------------------------
// fco_cordic: iterative rotation-mode CORDIC, sine and cosine of a Q.16 angle
// One micro-rotation per cycle; a load step, CORDIC_STEPS micro-rotation steps, a rounding step.
// ----------------------------------------------------------------------------
module fco_cordic import fco_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output trig_res_t               res
);

  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic                   neg_r;
  logic [STEP_W-1:0]      step_r;
  logic                   busy_r, fin_r, done_r;
  logic signed [VEC_W-1:0] sin_r, cos_r;

  logic signed [Z_W-1:0]    z_in;
  logic signed [XY_W-1:0]   xs, ys, xf, yf;
  logic signed [Z_W-1:0]    at;
  logic signed [PROD_W-1:0] xr, yr;
  logic                     last_step;

  assign z_in = Z_W'(angle);
  assign xs   = x_r >>> step_r;
  assign ys   = y_r >>> step_r;
  assign at   = Z_W'(atan_deg(step_r));
  assign xf   = neg_r ? -x_r : x_r;
  assign yf   = neg_r ? -y_r : y_r;
  assign xr   = (PROD_W'(xf) + 50'sd32768) >>> 16;
  assign yr   = (PROD_W'(yf) + 50'sd32768) >>> 16;
  assign last_step = busy_r && (step_r == STEP_W'(CORDIC_STEPS - 1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= !start && last_step;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last_step) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: quadrant fold, micro-rotations, final rounding
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_START;
      y_r    <= '0;
      step_r <= '0;
      if (z_in > QUARTER_TURN) begin
        z_r   <= z_in - HALF_TURN_Z;
        neg_r <= 1'b1;
      end else if (z_in < -QUARTER_TURN) begin
        z_r   <= z_in + HALF_TURN_Z;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z_in;
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (fin_r) begin
      cos_r <= clamp_unit(xr);
      sin_r <= clamp_unit(yr);
    end
  end

  assign res.done  = done_r;
  assign res.sin_v = sin_r;
  assign res.cos_v = cos_r;

endmodule

### src/fly_camera_orientation_update.sv
// ----------------------------------------------------------------------------
// fly_camera_orientation_update: yaw/pitch fly camera state keeper
//
//   port group | dir | word contents
//   in_*       | in  | move or look command (tuser = mode)
//   out_*      | out | position and front/right/up vectors after the command
//   cfg_*      | in  | APB registers move_speed (0x0), look_gain (0x4)
//
// A move word goes through the shared multiplier (an unused direction skips it).
// A look word takes up to 6 wrap steps for yaw, then two CORDIC runs, one for
// yaw and one for pitch, then four multiplier passes.
// One word at a time; a finished word waits in the output register.
// rst_n is synchronous and restores the startup camera pose and registers.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update import fco_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: direction[2:0], time_step[18:3], look_dx[34:19], look_dy[50:35]
  input  logic [55:0]  in_tdata,
  // in_tuser: mode[0]
  input  logic         in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: pos_x, pos_y, pos_z (32 each), front_x..z, right_x..z,
  //            up_x..z (16 each), from bit 0 up
  output logic [239:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  state_t state_r, state_nxt;

  logic [15:0] ms_r, lg_r;
  logic signed [ANG_W-1:0] yaw_r, pitch_r;
  logic signed [POS_W-1:0] pos_r [3];
  logic signed [VEC_W-1:0] front_r [3];
  logic signed [VEC_W-1:0] right_r [3];
  logic signed [VEC_W-1:0] up_r [3];
  logic signed [VEC_W-1:0] sy_r, cy_r, sp_r, cp_r;

  logic [2:0]  dir_r;
  logic [15:0] ts_r;
  logic signed [15:0] dx_r, dy_r;
  logic [31:0] speed_r;
  logic [1:0]  k_r;
  logic signed [ACC_W-1:0] yacc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic out_valid_r;
  logic [239:0] out_data_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic in_acc, out_load, cstart;
  logic signed [ANG_W-1:0] cangle;
  trig_res_t trig;

  // APB
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= 16'd768;
      lg_r <= 16'd6554;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_MOVE_SPEED: ms_r <= cfg_pwdata[15:0];
        REG_LOOK_GAIN:  lg_r <= cfg_pwdata[15:0];
      endcase
    end
  end
  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_MOVE_SPEED: cfg_prdata = {16'd0, ms_r};
      REG_LOOK_GAIN:  cfg_prdata = {16'd0, lg_r};
    endcase
  end

  // shared CORDIC
  fco_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cstart),
    .angle (cangle),
    .res   (trig)
  );

  // move helpers
  logic signed [VEC_W-1:0] mv_vec;
  logic mv_neg;
  logic signed [PROD_W-1:0] d_full;
  logic signed [33:0] d_ext, p_sum;
  logic signed [POS_W-1:0] p_sat;
  always_comb begin
    unique case (dir_r[2:1])
      2'd0:    mv_vec = front_r[k_r];
      2'd1:    mv_vec = right_r[k_r];
      default: mv_vec = up_r[k_r];
    endcase
    mv_neg = (dir_r == DIR_BACK) || (dir_r == DIR_LEFT) || (dir_r == DIR_DOWN);
    d_full = (prod_r + 50'sd2097152) >>> 22;
    d_ext  = d_full[33:0];
    p_sum  = mv_neg ? 34'(pos_r[k_r]) - d_ext : 34'(pos_r[k_r]) + d_ext;
    if (p_sum > 34'sd2147483647) p_sat = 32'sh7fffffff;
    else if (p_sum < -34'sd2147483648) p_sat = 32'sh80000000;
    else p_sat = p_sum[POS_W-1:0];
  end

  // look helpers
  logic signed [PROD_W-1:0] dang_full;
  logic signed [ACC_W-1:0]  dang, pacc;
  assign dang_full = (prod_r + 50'sd8) >>> 4;
  assign dang      = dang_full[ACC_W-1:0];
  assign pacc      = ACC_W'(pitch_r) + dang;

  // sequencer and multiplier operands
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    cstart    = 1'b0;
    cangle    = pitch_r;
    out_load  = 1'b0;
    in_tready = (state_r == S_IDLE);
    in_acc    = in_tvalid && in_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) state_nxt = S_LK_DX;
          else if (in_tdata[2:0] > DIR_DOWN) state_nxt = S_DONE;
          else state_nxt = S_MV_SPD;
        end
      end
      S_MV_SPD: begin
        mul_a = MUL_A_W'({1'b0, ms_r});
        mul_b = MUL_B_W'({1'b0, ts_r});
        state_nxt = S_MV_LAT;
      end
      S_MV_LAT: state_nxt = S_MV_VEC;
      S_MV_VEC: begin
        mul_a = MUL_A_W'(mv_vec);
        mul_b = {1'b0, speed_r};
        state_nxt = S_MV_ADD;
      end
      S_MV_ADD: state_nxt = (k_r == 2'd2) ? S_DONE : S_MV_VEC;
      S_LK_DX: begin
        mul_a = MUL_A_W'(dx_r);
        mul_b = MUL_B_W'({1'b0, lg_r});
        state_nxt = S_LK_DY;
      end
      S_LK_DY: begin
        mul_a = MUL_A_W'(dy_r);
        mul_b = MUL_B_W'({1'b0, lg_r});
        state_nxt = S_LK_PIT;
      end
      S_LK_PIT: state_nxt = S_LK_WRAP;
      S_LK_WRAP: begin
        if (yacc_r >= 0 && yacc_r < FULL_TURN) begin
          cstart    = 1'b1;
          cangle    = ANG_W'(yacc_r - HALF_TURN);
          state_nxt = S_CY;
        end
      end
      S_CY: begin
        if (trig.done) begin
          cstart    = 1'b1;
          state_nxt = S_CP;
        end
      end
      S_CP: if (trig.done) state_nxt = S_M0;
      S_M0: begin
        mul_a = MUL_A_W'(cy_r);
        mul_b = MUL_B_W'(cp_r);
        state_nxt = S_M1;
      end
      S_M1: begin
        mul_a = MUL_A_W'(sy_r);
        mul_b = MUL_B_W'(cp_r);
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_a = MUL_A_W'(cy_r);
        mul_b = MUL_B_W'(sp_r);
        state_nxt = S_M3;
      end
      S_M3: begin
        mul_a = MUL_A_W'(sy_r);
        mul_b = MUL_B_W'(sp_r);
        state_nxt = S_M4;
      end
      S_M4: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // camera state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r      <= YAW_RESET;
      pitch_r    <= PITCH_RESET;
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      pos_r[2]   <= POS_Z_RESET;
      front_r[0] <= 16'sd0;
      front_r[1] <= -16'sd2845;
      front_r[2] <= -16'sd16135;
      right_r[0] <= 16'sd16384;
      right_r[1] <= 16'sd0;
      right_r[2] <= 16'sd0;
      up_r[0]    <= 16'sd0;
      up_r[1]    <= 16'sd16135;
      up_r[2]    <= -16'sd2845;
    end else begin
      unique case (state_r)
        S_MV_ADD:  pos_r[k_r] <= p_sat;
        S_LK_PIT: begin
          if (pacc > PITCH_LIMIT) pitch_r <= PITCH_LIMIT[ANG_W-1:0];
          else if (pacc < -PITCH_LIMIT) pitch_r <= ANG_W'(-PITCH_LIMIT);
          else pitch_r <= pacc[ANG_W-1:0];
        end
        S_LK_WRAP: if (cstart) yaw_r <= cangle;
        S_M1: front_r[0] <= mul14(prod_r);
        S_M2: front_r[2] <= mul14(prod_r);
        S_M3: up_r[0]    <= -mul14(prod_r);
        S_M4: begin
          up_r[2]    <= -mul14(prod_r);
          front_r[1] <= sp_r;
          right_r[0] <= -sy_r;
          right_r[1] <= '0;
          right_r[2] <= cy_r;
          up_r[1]    <= cp_r;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dir_r <= in_tdata[2:0];
      ts_r  <= in_tdata[18:3];
      dx_r  <= in_tdata[34:19];
      dy_r  <= in_tdata[50:35];
    end
    unique case (state_r)
      S_MV_LAT: begin
        speed_r <= prod_r[31:0];
        k_r     <= '0;
      end
      S_MV_ADD: k_r <= k_r + 1'b1;
      S_LK_DY:  yacc_r <= ACC_W'(yaw_r) + dang + HALF_TURN;
      S_LK_WRAP: begin
        if (yacc_r >= FULL_TURN) yacc_r <= yacc_r - FULL_TURN;
        else if (yacc_r < 0) yacc_r <= yacc_r + FULL_TURN;
      end
      S_CY: if (trig.done) begin
        sy_r <= trig.sin_v;
        cy_r <= trig.cos_v;
      end
      S_CP: if (trig.done) begin
        sp_r <= trig.sin_v;
        cp_r <= trig.cos_v;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {up_r[2], up_r[1], up_r[0], right_r[2], right_r[1], right_r[0],
                     front_r[2], front_r[1], front_r[0], pos_r[2], pos_r[1], pos_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
